### sv/tssc_pkg.sv
// Shared types and constants for the terrain step-cost stencil.
// Holds register indexes, cost codes, the stored cell format and the
// command and status groups between the controller and the datapath.
package tssc_pkg;

  // Largest row length the line history is sized for.
  localparam int unsigned DEF_MAX_WIDTH = 1024;

  // Stream and configuration port widths.
  localparam int unsigned TDATA_IN_W  = 40;
  localparam int unsigned TUSER_IN_W  = 2;
  localparam int unsigned TDATA_OUT_W = 8;
  localparam int unsigned TUSER_OUT_W = 2;
  localparam int unsigned CFG_AW      = 3;
  localparam int unsigned CFG_DW      = 16;

  // Configuration register indexes.
  typedef enum logic [CFG_AW-1:0] {
    REG_MAP_WIDTH      = 3'd0,
    REG_BODY_HEIGHT    = 3'd1,
    REG_MAX_STEP       = 3'd2,
    REG_FLAT_THRESHOLD = 3'd3,
    REG_COST_SCALE     = 3'd4
  } reg_idx_e;

  // Register values after reset.
  localparam logic [10:0] RST_MAP_WIDTH      = 11'd1024;
  localparam logic [15:0] RST_BODY_HEIGHT    = 16'd614;
  localparam logic [15:0] RST_MAX_STEP       = 16'd205;
  localparam logic [15:0] RST_FLAT_THRESHOLD = 16'd20;
  localparam logic [7:0]  RST_COST_SCALE     = 8'd120;

  // Cost byte codes.
  localparam logic [7:0] COST_UNKNOWN = 8'd255;
  localparam logic [7:0] COST_LETHAL  = 8'd254;
  localparam logic [7:0] COST_CAP     = 8'd253;
  localparam logic [7:0] COST_FREE    = 8'd0;

  typedef enum logic [1:0] {
    CLS_UNKNOWN = 2'd0,
    CLS_FREE    = 2'd1,
    CLS_STEP    = 2'd2,
    CLS_LETHAL  = 2'd3
  } cell_class_e;

  // Window slots that are fetched from the line history.
  typedef enum logic [2:0] {
    TAP_MID_NEW = 3'd0,
    TAP_TOP_NEW = 3'd1,
    TAP_MID_CEN = 3'd2,
    TAP_MID_OLD = 3'd3,
    TAP_TOP_CEN = 3'd4,
    TAP_TOP_OLD = 3'd5
  } tap_e;

  localparam logic [2:0] LAST_TAP_SHIFT = 3'd1;
  localparam logic [2:0] LAST_TAP_FULL  = 3'd5;

  // Rounding divider: quotient bits and remainder width.
  localparam int unsigned QUOT_W = 9;
  localparam int unsigned REM_W  = 26;
  localparam logic [3:0]  DIV_TOP = 4'd8;

  // One stored grid cell.
  typedef struct packed {
    logic               pad;
    logic               ok;
    logic signed [15:0] g;
    logic signed [15:0] t;
  } cell_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic accept;
    logic rd_en;
    tap_e rd_tap;
    logic clr_refill;
    logic diff;
    logic max;
    logic mul;
    logic div;
    logic load;
  } tssc_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic refill;
    logic has_res;
    logic need_div;
    logic div_last;
    logic out_busy;
  } tssc_sts_t;

endpackage

### sv/tssc_ctrl.sv
// Sequencer for the terrain step-cost stencil.
// Steps each item through history reads, neighbor differences, maximum, scaling,
// division where a scaled step cost needs it and the output load; depends on tssc_pkg.
module tssc_ctrl import tssc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  tssc_sts_t sts_i,
  output tssc_cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_LAND = 3'd2;
  localparam logic [2:0] ST_DIFF = 3'd3;
  localparam logic [2:0] ST_MAX  = 3'd4;
  localparam logic [2:0] ST_MUL  = 3'd5;
  localparam logic [2:0] ST_DIV  = 3'd6;
  localparam logic [2:0] ST_FIN  = 3'd7;

  logic [2:0] state_q, state_d;
  logic [2:0] rd_cnt_q, rd_cnt_d;
  logic       last_tap;

  assign in_ready_o = (state_q == ST_IDLE);
  assign last_tap   = (rd_cnt_q == (sts_i.refill ? LAST_TAP_FULL : LAST_TAP_SHIFT));

  // Next state and command decode.
  always_comb begin
    state_d  = state_q;
    rd_cnt_d = rd_cnt_q;
    cmd_o    = '0;
    cmd_o.rd_tap = tap_e'(rd_cnt_q);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          rd_cnt_d     = '0;
          state_d      = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        rd_cnt_d    = rd_cnt_q + 3'd1;
        if (last_tap) begin
          state_d = ST_LAND;
        end
      end
      ST_LAND: begin
        cmd_o.clr_refill = 1'b1;
        state_d          = ST_DIFF;
      end
      ST_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = ST_MAX;
      end
      ST_MAX: begin
        cmd_o.max = 1'b1;
        state_d   = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        if (!sts_i.has_res) begin
          state_d = ST_IDLE;
        end else if (sts_i.need_div) begin
          state_d = ST_DIV;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rd_cnt_q <= '0;
    end else begin
      state_q  <= state_d;
      rd_cnt_q <= rd_cnt_d;
    end
  end

endmodule

### sv/tssc_datapath.sv
// Datapath of the terrain step-cost stencil: configuration registers,
// line history memory, 3x3 window, step search, rounding divider and
// output register; depends on tssc_pkg.
module tssc_datapath import tssc_pkg::*; #(
  parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_AW-1:0]       cfg_addr_i,
  input  logic [CFG_DW-1:0]       cfg_wdata_i,
  input  logic [TDATA_IN_W-1:0]   in_data_i,
  input  logic [TUSER_IN_W-1:0]   in_user_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [TDATA_OUT_W-1:0]  out_data_o,
  output logic [TUSER_OUT_W-1:0]  out_user_o,
  input  tssc_cmd_t               cmd_i,
  output tssc_sts_t               sts_o
);

  localparam int unsigned HIST_LEN = 2 * MAX_WIDTH + 3;
  localparam int unsigned PTR_W    = $clog2(HIST_LEN);
  localparam int unsigned SEEN_W   = $clog2(HIST_LEN + 1);
  localparam int unsigned ADR_W    = SEEN_W + 1;
  localparam int unsigned COL_W    = $clog2(MAX_WIDTH);
  localparam int unsigned WID_W    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CLMP_W   = (WID_W > 11) ? WID_W : 11;
  localparam int unsigned RST_W_INT =
    (RST_MAP_WIDTH == 11'd0) ? 1 :
    ((int'(RST_MAP_WIDTH) > int'(MAX_WIDTH)) ? MAX_WIDTH : int'(RST_MAP_WIDTH));

  // Configuration registers; the row length is stored already clamped.
  logic [WID_W-1:0] w_q;
  logic [15:0]      body_q, maxs_q, flat_q;
  logic [7:0]       scale_q;
  logic             refill_q;
  logic [CLMP_W-1:0] mw_ext;
  logic [WID_W-1:0]  w_new;

  assign cfg_ready_o = 1'b1;
  assign mw_ext      = CLMP_W'(cfg_wdata_i[10:0]);
  assign w_new       = (mw_ext == '0) ? WID_W'(1) :
                       ((mw_ext > CLMP_W'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH) : WID_W'(mw_ext));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q      <= WID_W'(RST_W_INT);
      body_q   <= RST_BODY_HEIGHT;
      maxs_q   <= RST_MAX_STEP;
      flat_q   <= RST_FLAT_THRESHOLD;
      scale_q  <= RST_COST_SCALE;
      refill_q <= 1'b0;
    end else begin
      if (cmd_i.clr_refill) begin
        refill_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        unique case (cfg_addr_i)
          REG_MAP_WIDTH: begin
            w_q      <= w_new;
            refill_q <= 1'b1;
          end
          REG_BODY_HEIGHT:    body_q  <= cfg_wdata_i;
          REG_MAX_STEP:       maxs_q  <= cfg_wdata_i;
          REG_FLAT_THRESHOLD: flat_q  <= cfg_wdata_i;
          REG_COST_SCALE:     scale_q <= cfg_wdata_i[7:0];
          default: ;
        endcase
      end
    end
  end

  // Incoming cell and raster position bookkeeping.
  cell_t             new_cell;
  logic              map_start;
  logic [COL_W-1:0]  col_q, col_d, col_base, cur_col, cur_col_q;
  logic [SEEN_W-1:0] seen_q, seen_d, seen_base, w_ext;
  logic [PTR_W-1:0]  wrp_q, wrp_d;

  assign map_start    = in_user_i[0];
  assign new_cell.pad = in_user_i[1];
  assign new_cell.ok  = !in_user_i[1] && in_data_i[0];
  assign new_cell.g   = in_data_i[16:1];
  assign new_cell.t   = in_data_i[32:17];
  assign w_ext        = SEEN_W'(w_q);

  always_comb begin
    col_base  = map_start ? '0 : col_q;
    seen_base = map_start ? '0 : seen_q;
    cur_col   = (WID_W'(col_base) >= w_q) ? '0 : col_base;
    col_d     = ((WID_W'(cur_col) + WID_W'(1)) >= w_q) ? '0 : (cur_col + COL_W'(1));
    seen_d    = (seen_base < SEEN_W'(HIST_LEN)) ? (seen_base + SEEN_W'(1)) : seen_base;
    wrp_d     = (wrp_q == PTR_W'(HIST_LEN - 1)) ? '0 : (wrp_q + PTR_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      seen_q <= '0;
      wrp_q  <= '0;
    end else if (cmd_i.accept) begin
      col_q  <= col_d;
      seen_q <= seen_d;
      wrp_q  <= wrp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cur_col_q <= cur_col;
    end
  end

  // History read address: the slot a given number of items back.
  logic [SEEN_W-1:0] rd_back;
  logic [ADR_W-1:0]  a_ext, b_ext;
  logic [PTR_W-1:0]  rd_addr;

  always_comb begin
    case (cmd_i.rd_tap)
      TAP_MID_NEW: rd_back = w_ext;
      TAP_TOP_NEW: rd_back = w_ext + w_ext;
      TAP_MID_CEN: rd_back = w_ext + SEEN_W'(1);
      TAP_MID_OLD: rd_back = w_ext + SEEN_W'(2);
      TAP_TOP_CEN: rd_back = w_ext + w_ext + SEEN_W'(1);
      TAP_TOP_OLD: rd_back = w_ext + w_ext + SEEN_W'(2);
      default:     rd_back = w_ext;
    endcase
    a_ext   = ADR_W'(wrp_q);
    b_ext   = ADR_W'(rd_back);
    rd_addr = (a_ext >= b_ext) ? PTR_W'(a_ext - b_ext)
                               : PTR_W'(a_ext + ADR_W'(HIST_LEN) - b_ext);
  end

  // Line history memory: one write and one registered read per cycle.
  cell_t hist_mem [HIST_LEN];
  cell_t rd_data_q;
  logic  rd_vld_q;
  tap_e  rd_tag_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      hist_mem[wrp_d] <= new_cell;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= hist_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      rd_tag_q <= TAP_MID_NEW;
    end else begin
      rd_vld_q <= cmd_i.rd_en;
      rd_tag_q <= cmd_i.rd_tap;
    end
  end

  // 3x3 window; index 0 of each row is the newest item of that row.
  cell_t bot_q [3];
  cell_t mid_q [3];
  cell_t top_q [3];

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      bot_q[0] <= new_cell;
      bot_q[1] <= bot_q[0];
      bot_q[2] <= bot_q[1];
      mid_q[1] <= mid_q[0];
      mid_q[2] <= mid_q[1];
      top_q[1] <= top_q[0];
      top_q[2] <= top_q[1];
    end else if (rd_vld_q) begin
      case (rd_tag_q)
        TAP_MID_NEW: mid_q[0] <= rd_data_q;
        TAP_TOP_NEW: top_q[0] <= rd_data_q;
        TAP_MID_CEN: mid_q[1] <= rd_data_q;
        TAP_MID_OLD: mid_q[2] <= rd_data_q;
        TAP_TOP_CEN: top_q[1] <= rd_data_q;
        TAP_TOP_OLD: top_q[2] <= rd_data_q;
        default: ;
      endcase
    end
  end

  // Neighbor differences, presence and span check.
  cell_t             cen;
  cell_t             nb [8];
  logic [SEEN_W-1:0] nb_back [8];
  logic [7:0]        side_ok;
  logic [COL_W-1:0]  cen_col;
  logic              left_ok, right_ok;
  logic [15:0]       dif_d [8];
  logic [7:0]        use_d;
  logic signed [16:0] dg, sp;
  logic              span_d, has_res_d;

  logic [15:0] dif_q [8];
  logic [7:0]  use_q;
  logic        span_q, has_res_q, cen_ok_q;

  always_comb begin
    cen      = mid_q[1];
    cen_col  = (cur_col_q == '0) ? COL_W'(w_q - WID_W'(1)) : (cur_col_q - COL_W'(1));
    left_ok  = (cen_col != '0);
    right_ok = (WID_W'(cen_col) != (w_q - WID_W'(1)));
    nb[0] = top_q[2]; nb_back[0] = w_ext + w_ext + SEEN_W'(2); side_ok[0] = left_ok;
    nb[1] = top_q[1]; nb_back[1] = w_ext + w_ext + SEEN_W'(1); side_ok[1] = 1'b1;
    nb[2] = top_q[0]; nb_back[2] = w_ext + w_ext;              side_ok[2] = right_ok;
    nb[3] = mid_q[2]; nb_back[3] = w_ext + SEEN_W'(2);         side_ok[3] = left_ok;
    nb[4] = mid_q[0]; nb_back[4] = w_ext;                      side_ok[4] = right_ok;
    nb[5] = bot_q[2]; nb_back[5] = SEEN_W'(2);                 side_ok[5] = left_ok;
    nb[6] = bot_q[1]; nb_back[6] = SEEN_W'(1);                 side_ok[6] = 1'b1;
    nb[7] = bot_q[0]; nb_back[7] = '0;                         side_ok[7] = right_ok;
    for (int k = 0; k < 8; k++) begin
      dg       = 17'(nb[k].g) - 17'(cen.g);
      dif_d[k] = dg[16] ? 16'(-dg) : dg[15:0];
      use_d[k] = (nb_back[k] < seen_q) && nb[k].ok && side_ok[k];
    end
    sp        = 17'(cen.t) - 17'(cen.g);
    span_d    = $signed({sp[16], sp}) > $signed({2'b00, body_q});
    has_res_d = (seen_q > (w_ext + SEEN_W'(1))) && !cen.pad;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.diff) begin
      dif_q     <= dif_d;
      use_q     <= use_d;
      span_q    <= span_d;
      has_res_q <= has_res_d;
      cen_ok_q  <= cen.ok;
    end
  end

  // Largest step over the used neighbors, a three-level tree.
  logic [15:0] lvl0 [8];
  logic [15:0] lvl1 [4];
  logic [15:0] lvl2 [2];
  logic [15:0] biggest_d, biggest_q;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      lvl0[k] = use_q[k] ? dif_q[k] : 16'd0;
    end
    for (int k = 0; k < 4; k++) begin
      lvl1[k] = (lvl0[2*k] > lvl0[2*k+1]) ? lvl0[2*k] : lvl0[2*k+1];
    end
    for (int k = 0; k < 2; k++) begin
      lvl2[k] = (lvl1[2*k] > lvl1[2*k+1]) ? lvl1[2*k] : lvl1[2*k+1];
    end
    biggest_d = (lvl2[0] > lvl2[1]) ? lvl2[0] : lvl2[1];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.max) begin
      biggest_q <= biggest_d;
    end
  end

  // Cost decision flags.
  logic step_leth, steppy;

  assign step_leth = (biggest_q > maxs_q);
  assign steppy    = (biggest_q > flat_q) && (maxs_q != 16'd0);

  // Scaling and restoring division, one quotient bit per cycle:
  // q = floor((2 * step * scale + max_step) / (2 * max_step)).
  logic [23:0]       prod;
  logic [REM_W-1:0]  rem_q, trial;
  logic [QUOT_W-1:0] quot_q;
  logic [3:0]        div_i_q;

  assign prod  = biggest_q * scale_q;
  assign trial = REM_W'({maxs_q, 1'b0}) << div_i_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      rem_q   <= REM_W'({prod, 1'b0}) + REM_W'(maxs_q);
      quot_q  <= '0;
      div_i_q <= DIV_TOP;
    end else if (cmd_i.div) begin
      if (rem_q >= trial) begin
        rem_q           <= rem_q - trial;
        quot_q[div_i_q] <= 1'b1;
      end
      div_i_q <= div_i_q - 4'd1;
    end
  end

  // Output register.
  logic        out_valid_q;
  logic [7:0]  out_cost_q, cost_d;
  cell_class_e out_class_q, class_d;

  always_comb begin
    if (!cen_ok_q) begin
      cost_d  = COST_UNKNOWN;
      class_d = CLS_UNKNOWN;
    end else if (span_q || step_leth) begin
      cost_d  = COST_LETHAL;
      class_d = CLS_LETHAL;
    end else if (steppy) begin
      cost_d  = (quot_q > QUOT_W'(COST_CAP)) ? COST_CAP : quot_q[7:0];
      class_d = CLS_STEP;
    end else begin
      cost_d  = COST_FREE;
      class_d = CLS_FREE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_cost_q  <= cost_d;
      out_class_q <= class_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_cost_q;
  assign out_user_o  = out_class_q;

  // Status to the controller.
  assign sts_o.refill   = refill_q;
  assign sts_o.has_res  = has_res_q;
  assign sts_o.need_div = cen_ok_q && !span_q && !step_leth && steppy;
  assign sts_o.div_last = (div_i_q == 4'd0);
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

`ifndef SYNTHESIS
  // A history read never lands in the cycle the window shifts.
  assert property (@(posedge clk_i) disable iff (!rst_ni) rd_vld_q |-> !cmd_i.accept)
    else $error("history read landed during a window shift");

  // The rounded quotient always fits the divider's quotient bits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.div && (div_i_q == DIV_TOP)) |-> (rem_q < (REM_W'({maxs_q, 1'b0}) << QUOT_W)))
    else $error("divider quotient overflow");

  // A loaded result shows up, and the unknown code goes with the unknown class.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> (out_valid_q &&
                    ((out_class_q == CLS_UNKNOWN) == (out_cost_q == COST_UNKNOWN))))
    else $error("result register mismatch after load");

  // The item count saturates at the history length.
  assert property (@(posedge clk_i) disable iff (!rst_ni) seen_q <= SEEN_W'(HIST_LEN))
    else $error("item count beyond history length");
`endif

endmodule

### sv/terrain_step_cost_stencil.sv
// Terrain step-cost stencil: 3x3 window over a raster height grid.
// Items are taken one at a time: a new item is accepted only once the last one is done,
// and the item after a map_width write first refills the mid and top window rows.
// The single read port of the line history and the bit-serial divider limit the item rate.
// Reset clears control and registers at once; the history needs no clearing pass.
module terrain_step_cost_stencil import tssc_pkg::*; #(
  parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration write channel.
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_AW-1:0]      cfg_addr_i,
  input  logic [CFG_DW-1:0]      cfg_wdata_i,
  // Input cells.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // cell_valid [0], ground_height [16:1], top_height [32:17], zero [39:33]
  input  logic [TDATA_IN_W-1:0]  s_axis_tdata,
  // map_start [0], padding [1]
  input  logic [TUSER_IN_W-1:0]  s_axis_tuser,
  // Output costs.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // cell_cost [7:0]
  output logic [TDATA_OUT_W-1:0] m_axis_tdata,
  // cell_class [1:0]
  output logic [TUSER_OUT_W-1:0] m_axis_tuser
);

  tssc_cmd_t cmd;
  tssc_sts_t sts;

  // Sequencer.
  tssc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Storage and arithmetic.
  tssc_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

### tb/tb.sv
// Self-checking bench for the terrain step-cost stencil: directed and random grid maps.
// A scoreboard class predicts every cost byte from its own copy of the window history.
// Depends on tssc_pkg for port widths, register indexes and cost and class codes.
`timescale 1ns / 100ps

import tssc_pkg::*;

// Tracks the stencil state, predicts cost bytes and checks the block's output against them.
class cost_scoreboard;
  localparam int HIST_LEN = 2 * DEF_MAX_WIDTH + 3;

  typedef struct {
    logic [7:0]  cost;
    cell_class_e cls;
  } cost_item_t;

  cell_t       cell_hist [HIST_LEN];
  int          wr_pos;
  int          col_cnt;
  int          seen_cnt;
  logic [10:0] width_r;
  logic [15:0] body_r;
  logic [15:0] max_step_r;
  logic [15:0] flat_r;
  logic [7:0]  scale_r;
  cost_item_t  costs_due [$];
  int unsigned errors;

  function new();
    for (int i = 0; i < HIST_LEN; i++) begin
      cell_hist[i] = '{pad: 1'b1, ok: 1'b0, g: '0, t: '0};
    end
    wr_pos     = 0;
    col_cnt    = 0;
    seen_cnt   = 0;
    width_r    = RST_MAP_WIDTH;
    body_r     = RST_BODY_HEIGHT;
    max_step_r = RST_MAX_STEP;
    flat_r     = RST_FLAT_THRESHOLD;
    scale_r    = RST_COST_SCALE;
    errors     = 0;
  endfunction

  // Mirror one accepted register write.
  function void set_reg(input reg_idx_e idx, input logic [15:0] val);
    case (idx)
      REG_MAP_WIDTH:      width_r    = val[10:0];
      REG_BODY_HEIGHT:    body_r     = val;
      REG_MAX_STEP:       max_step_r = val;
      REG_FLAT_THRESHOLD: flat_r     = val;
      REG_COST_SCALE:     scale_r    = val[7:0];
      default: ;
    endcase
  endfunction

  function cell_t cell_back(input int back);
    return cell_hist[(wr_pos + HIST_LEN - (back % HIST_LEN)) % HIST_LEN];
  endfunction

  // Push one accepted cell into the history and queue the cost it releases, if any.
  function void note_cell(input logic st, input logic pd, input logic vl,
                          input logic [15:0] g, input logic [15:0] t);
    int         w;
    int         cur;
    int         cen_col;
    int         nc;
    int         back;
    int         cg;
    int         ct;
    int         ng;
    int         d;
    int         biggest;
    longint     num;
    longint     quo;
    cell_t      c;
    cell_t      cen;
    cell_t      nb;
    cost_item_t res;
    w = width_r;
    if (w < 1) w = 1;
    if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
    if (st) begin
      col_cnt  = 0;
      seen_cnt = 0;
    end
    if (col_cnt >= w) col_cnt = 0;
    c.pad = pd;
    c.ok  = !pd && vl;
    c.g   = g;
    c.t   = t;
    wr_pos = (wr_pos + 1) % HIST_LEN;
    cell_hist[wr_pos] = c;
    if (seen_cnt < HIST_LEN) seen_cnt++;
    cur = col_cnt;
    col_cnt = (cur + 1 >= w) ? 0 : cur + 1;

    // The window is full only once a row and two cells of the map are in.
    if (seen_cnt <= w + 1) return;
    cen = cell_back(w + 1);
    if (cen.pad) return;
    cen_col = (cur == 0) ? w - 1 : cur - 1;
    cg = cen.g;
    ct = cen.t;
    biggest = 0;

    if (!cen.ok) begin
      res = '{COST_UNKNOWN, CLS_UNKNOWN};
    end else if (ct - cg > int'(body_r)) begin
      res = '{COST_LETHAL, CLS_LETHAL};
    end else begin
      // Largest ground step to any valid neighbor inside the map.
      for (int dr = -1; dr <= 1; dr++) begin
        for (int dc = -1; dc <= 1; dc++) begin
          nc = cen_col + dc;
          back = w + 1 - dr * w - dc;
          if (!(dr == 0 && dc == 0) && nc >= 0 && nc < w && back >= 0 &&
              back < seen_cnt) begin
            nb = cell_back(back);
            if (nb.ok) begin
              ng = nb.g;
              d = (ng > cg) ? ng - cg : cg - ng;
              if (d > biggest) biggest = d;
            end
          end
        end
      end
      if (biggest > int'(max_step_r)) begin
        res = '{COST_LETHAL, CLS_LETHAL};
      end else if (biggest > int'(flat_r) && max_step_r != 0) begin
        num = 2 * longint'(biggest) * longint'(scale_r) + longint'(max_step_r);
        quo = num / (2 * longint'(max_step_r));
        res.cost = (quo > 253) ? COST_CAP : quo[7:0];
        res.cls  = CLS_STEP;
      end else begin
        res = '{COST_FREE, CLS_FREE};
      end
    end
    costs_due.push_back(res);
  endfunction

  // Compare one transfer on the output against the oldest queued cost.
  function void check_cost(input logic [7:0] cost, input logic [1:0] cls);
    cost_item_t exp_item;
    if (costs_due.size() == 0) begin
      $error("unexpected result: cell_cost %0d cell_class %0d", cost, cls);
      errors++;
      return;
    end
    exp_item = costs_due.pop_front();
    if (cost !== exp_item.cost) begin
      $error("cell_cost mismatch: expected %0d, actual %0d", exp_item.cost, cost);
      errors++;
    end
    if (cls !== exp_item.cls) begin
      $error("cell_class mismatch: expected %0d, actual %0d", exp_item.cls, cls);
      errors++;
    end
  endfunction
endclass

module tb;
  localparam int RAND_ITEMS      = 850;
  localparam int SETTLE_CYCLES   = 32;
  localparam int WATCHDOG_CYCLES = 5000;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_AW-1:0]      cfg_addr_i;
  logic [CFG_DW-1:0]      cfg_wdata_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [TDATA_IN_W-1:0]  s_axis_tdata;
  logic [TUSER_IN_W-1:0]  s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [TDATA_OUT_W-1:0] m_axis_tdata;
  logic [TUSER_OUT_W-1:0] m_axis_tuser;

  cost_scoreboard sb;
  int  n_sent;
  int  weff;
  int  h_spread;
  int  span_lim;
  int  map_base;
  int  idle_cycles;
  bit  snd_burst;
  bit  rcv_burst;

  terrain_step_cost_stencil uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 50 MHz clock.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Ground heights cluster around the map base so that steps land near max_step.
  function automatic logic [15:0] pick_ground();
    int          r;
    logic [15:0] v;
    r = $urandom_range(0, 9);
    if (r == 0) v = $urandom();
    else if (r < 3) v = map_base;
    else v = map_base + int'($urandom_range(0, 2 * h_spread)) - h_spread;
    return v;
  endfunction

  function automatic logic [15:0] pick_top(input logic [15:0] g);
    logic [15:0] v;
    if ($urandom_range(0, 9) == 0) v = $urandom();
    else v = g + $urandom_range(0, span_lim);
    return v;
  endfunction

  // Send one cell; the sender may idle first, or hold off until every cost is out.
  task automatic send_cell(input logic st, input logic pd, input logic vl,
                           input logic [15:0] g, input logic [15:0] t);
    int gap;
    bit hold;
    if ($urandom_range(0, 39) == 0) snd_burst = ~snd_burst;
    gap = snd_burst ? 0 : $urandom_range(0, 8);
    hold = ($urandom_range(0, 79) == 0);
    if (hold && gap == 0) gap = 1;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      while (hold && sb.costs_due.size() != 0) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, t, g, vl};
    s_axis_tuser  <= {pd, st};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_cell(st, pd, vl, g, t);
    n_sent++;
  endtask

  // A run of real cells; with noise, stray start and padding flags appear.
  task automatic send_cells(input int n, input bit start_first, input bit noise);
    logic        st;
    logic        pd;
    logic [15:0] g;
    if (start_first) map_base = int'($urandom_range(0, 40000)) - 20000;
    for (int i = 0; i < n; i++) begin
      st = start_first && i == 0;
      pd = 1'b0;
      if (noise) begin
        if ($urandom_range(0, 24) == 0) st = ~st;
        if ($urandom_range(0, 19) == 0) pd = 1'b1;
      end
      g = pick_ground();
      send_cell(st, pd, $urandom_range(0, 9) != 0, g, pick_top(g));
    end
  endtask

  // Trailing flush cells; their content must not matter.
  task automatic send_pad(input int n, input bit noise);
    for (int i = 0; i < n; i++) begin
      send_cell(noise && $urandom_range(0, 30) == 0, 1'b1, $urandom_range(0, 1),
                $urandom(), $urandom());
    end
  endtask

  task automatic send_map(input int rows, input bit noise);
    send_cells(rows * weff, 1'b1, noise);
    send_pad(noise ? $urandom_range(0, weff + 1) : weff + 1, noise);
  endtask

  // Stop sending, wait for every queued cost, then let the pipeline go quiet.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.costs_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  // Program all registers while the block is idle.
  task automatic set_phase(input int w, input int bh, input int ms, input int ft,
                           input int cs);
    settle();
    write_reg(REG_MAP_WIDTH, w);
    write_reg(REG_BODY_HEIGHT, bh);
    write_reg(REG_MAX_STEP, ms);
    write_reg(REG_FLAT_THRESHOLD, ft);
    write_reg(REG_COST_SCALE, cs);
    cfg_valid_i <= 1'b0;
    weff = (w == 0) ? 1 : ((w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : w);
    h_spread = (ms == 0) ? 3 : ((ms > 13000) ? 20000 : ms * 3 / 2 + 1);
    span_lim = (bh > 32000) ? 40000 : bh + bh / 4 + 8;
  endtask

  // Receiver: idles a random number of cycles before taking each result.
  initial begin
    int gap;
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) rcv_burst = ~rcv_burst;
      gap = rcv_burst ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  // Check every result transfer.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_cost(m_axis_tdata, m_axis_tuser);
  end

  // Watchdog: too long without any transfer means the block is stuck.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Main sequence.
  initial begin
    int ph;
    int goal;
    int pend;
    sb = new();
    n_sent    = 0;
    snd_burst = 1'b0;
    rcv_burst = 1'b0;
    weff      = DEF_MAX_WIDTH;
    h_spread  = 300;
    span_lim  = 800;
    map_base  = 0;
    idle_cycles   <= 0;
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_addr_i    <= REG_MAP_WIDTH;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at width 3; the stream starts without a map start flag.
    set_phase(3, 614, 205, 20, 120);
    send_cell(1'b0, 1'b0, 1'b1, 16'sd0, 16'sd100);
    send_cell(1'b0, 1'b0, 1'b1, -16'sd32768, 16'sd32767);
    send_cell(1'b0, 1'b0, 1'b0, 16'sd5, 16'sd5);
    send_cell(1'b0, 1'b0, 1'b1, 16'sd50, 16'sd60);
    send_cell(1'b0, 1'b0, 1'b1, 16'sd10, 16'sd10);
    send_cell(1'b0, 1'b0, 1'b1, 16'sd215, 16'sd215);
    send_cell(1'b0, 1'b0, 1'b1, 16'sd32767, -16'sd32768);
    send_cell(1'b0, 1'b0, 1'b1, 16'sd30, 16'sd30);
    send_cell(1'b0, 1'b0, 1'b1, 16'sd10, 16'sd624);
    send_cell(1'b0, 1'b1, 1'b1, 16'hFFFF, 16'h0000);
    send_cell(1'b0, 1'b1, 1'b0, 16'h0000, 16'hFFFF);
    send_cell(1'b0, 1'b1, 1'b1, 16'h5555, 16'hAAAA);
    send_cell(1'b0, 1'b1, 1'b0, 16'hAAAA, 16'h5555);
    // A new map whose first item is a flush cell.
    send_cell(1'b1, 1'b1, 1'b1, 16'sd0, 16'sd0);
    send_cell(1'b0, 1'b0, 1'b1, 16'sd0, 16'sd0);
    send_cell(1'b0, 1'b0, 1'b1, 16'sd21, 16'sd40);
    send_cell(1'b0, 1'b0, 1'b1, 16'sd20, 16'sd20);
    send_cell(1'b0, 1'b0, 1'b1, -16'sd185, 16'sd0);
    send_cell(1'b0, 1'b0, 1'b1, 16'sd1, 16'sd1);
    send_pad(4, 1'b0);

    // Full-width rows, at the top value and at an out-of-range width.
    set_phase(DEF_MAX_WIDTH, 614, 205, 20, 120);
    send_map(1, 1'b0);
    set_phase(2047, 800, 300, 30, 200);
    send_map(1, 1'b0);

    // Width shrinks in the middle of a map: the column count wraps.
    set_phase(6, 614, 205, 20, 120);
    send_cells(11, 1'b1, 1'b0);
    set_phase(4, 700, 150, 10, 90);
    send_cells(9, 1'b0, 1'b0);
    send_pad(5, 1'b0);

    // Random maps over a series of settings, corners first.
    ph = 0;
    goal = n_sent + RAND_ITEMS;
    while (n_sent < goal) begin
      case (ph)
        0: set_phase(1, $urandom_range(0, 1200), 0, 0, $urandom_range(0, 255));
        1: set_phase(0, 0, $urandom_range(1, 300), $urandom_range(0, 50), 120);
        2: set_phase(2, 65535, 65535, 0, 255);
        3: set_phase(7, $urandom_range(0, 1200), 1, 0, 253);
        4: set_phase(12, $urandom_range(0, 1200), $urandom_range(1, 400), 65535,
                     $urandom_range(0, 255));
        5: set_phase(5, $urandom_range(0, 1200), 65535, 65535, 0);
        default: begin
          pend = $urandom_range(1, 400);
          set_phase($urandom_range(1, 12),
                    ($urandom_range(0, 7) == 0) ? 65535 : $urandom_range(0, 1200),
                    pend, $urandom_range(0, pend), $urandom_range(0, 255));
        end
      endcase
      pend = n_sent + 100;
      while (n_sent < pend && n_sent < goal) begin
        send_map($urandom_range(1, 4), $urandom_range(0, 6) == 0);
      end
      ph++;
    end

    settle();
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
